FILE: hdl/hdf_pkg.sv
// Package for the heartbeat duplicate filter: field widths, status codes,
// register indexes and default parameter values.
// No dependencies.
`timescale 1ns / 1ps

package hdf_pkg;

   // Default table shape
   localparam int TABLE_ENTRIES_DEF = 16;
   localparam int KEY_BITS_DEF      = 64;

   // Fixed field widths
   localparam int KEY_PORT_W = 64;
   localparam int MED_W      = 3;
   localparam int TIME_W     = 48;
   localparam int CFG_W      = 32;
   localparam int STATUS_W   = 2;
   localparam int COUNT_W    = 5;
   localparam int CSR_IDX_W  = 2;

   // Status codes
   localparam logic [STATUS_W-1:0] STATUS_REFRESHED = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INSERTED  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_REPEATED  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd3;

   // Eviction count saturates here
   localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_REPEAT_WINDOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_LIFETIME = 2'd1;

   // Register reset values
   localparam logic [CFG_W-1:0] REPEAT_WINDOW_RST  = 32'd10000;
   localparam logic [CFG_W-1:0] ENTRY_LIFETIME_RST = 32'd3600000;

endpackage

FILE: hdl/hdf_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hdf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/heartbeat_duplicate_filter_unit.sv
// Heartbeat duplicate filter: aging duplicate-suppression table over one RAM.
// Depends on hdf_pkg and hdf_ram.
//
//   channel | direction | handshake          | payload
//   req_    | in        | req_valid/req_stall | device_key, disc_type, now_ms
//   rsp_    | out       | rsp_valid/rsp_stall | status, evicted_count
//   csr_    | in        | csr_valid/csr_ready | csr_index, csr_wdata
//
// Each request is scanned with one RAM read per table entry through the
// single read port; no new request is taken while a scan is under way.
// Synchronous active-high reset clears all valid bits and loads the
// register defaults; the RAM is not cleared, valid bits mask its contents.
// A stalled response waits in the output register; the next request is
// taken once the result has moved there.
`timescale 1ns / 1ps

module heartbeat_duplicate_filter_unit #(
   parameter int TABLE_ENTRIES = hdf_pkg::TABLE_ENTRIES_DEF,
   parameter int KEY_BITS      = hdf_pkg::KEY_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // request channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [hdf_pkg::KEY_PORT_W-1:0] req_device_key,
   input  logic [hdf_pkg::MED_W-1:0]      req_disc_type,
   input  logic [hdf_pkg::TIME_W-1:0]     req_now_ms,
   // response channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [hdf_pkg::STATUS_W-1:0]   rsp_status,
   output logic [hdf_pkg::COUNT_W-1:0]    rsp_evicted_count,
   // configuration write channel
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [hdf_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hdf_pkg::CFG_W-1:0]      csr_wdata
);

   localparam int IDX_W   = $clog2(TABLE_ENTRIES);
   localparam int ENTRY_W = KEY_BITS + hdf_pkg::MED_W + hdf_pkg::TIME_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
   localparam int TIME_PAD = hdf_pkg::TIME_W - hdf_pkg::CFG_W;

   // Sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_SCAN   = 3'd1;
   localparam logic [2:0] ST_TAIL   = 3'd2;
   localparam logic [2:0] ST_UPDATE = 3'd3;
   localparam logic [2:0] ST_DONE   = 3'd4;

   logic [2:0]                     state_ff, state_in;
   logic [hdf_pkg::CFG_W-1:0]      window_ff, window_in;
   logic [hdf_pkg::CFG_W-1:0]      lifetime_ff, lifetime_in;
   logic [TABLE_ENTRIES-1:0]       slot_valid_ff, slot_valid_in;

   // Latched request
   logic [KEY_BITS-1:0]            key_ff, key_in;
   logic [hdf_pkg::MED_W-1:0]      med_ff, med_in;
   logic [hdf_pkg::TIME_W-1:0]     now_ff, now_in;

   // Scan pipeline
   logic [IDX_W-1:0]               scan_ff, scan_in;
   logic                           chk_valid_ff, chk_valid_in;
   logic [IDX_W-1:0]               chk_idx_ff, chk_idx_in;

   // Scan results
   logic                           rep_ff, rep_in;
   logic                           hit_ff, hit_in;
   logic [IDX_W-1:0]               hit_idx_ff, hit_idx_in;
   logic                           free_ff, free_in;
   logic [IDX_W-1:0]               free_idx_ff, free_idx_in;
   logic [TABLE_ENTRIES-1:0]       stale_ff, stale_in;
   logic [hdf_pkg::COUNT_W-1:0]    cnt_ff, cnt_in;

   // Pending result and output register
   logic [hdf_pkg::STATUS_W-1:0]   res_status_ff, res_status_in;
   logic [hdf_pkg::COUNT_W-1:0]    res_count_ff, res_count_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [hdf_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [hdf_pkg::COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   // RAM ports
   logic                           ram_wr_en;
   logic [IDX_W-1:0]               ram_wr_addr;
   logic [ENTRY_W-1:0]             ram_wr_data;
   logic [ENTRY_W-1:0]             ram_rd_data;

   // Entry decode
   logic [KEY_BITS-1:0]            ent_key;
   logic [hdf_pkg::MED_W-1:0]      ent_med;
   logic [hdf_pkg::TIME_W-1:0]     ent_seen;
   logic [hdf_pkg::TIME_W-1:0]     ent_age;
   logic                           ent_valid;
   logic                           ent_match;
   logic                           ent_stale;

   hdf_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (scan_ff),
      .rd_data (ram_rd_data)
   );

   // Check of the entry read in the previous cycle
   assign ent_key   = ram_rd_data[ENTRY_W-1 -: KEY_BITS];
   assign ent_med   = ram_rd_data[hdf_pkg::TIME_W +: hdf_pkg::MED_W];
   assign ent_seen  = ram_rd_data[hdf_pkg::TIME_W-1:0];
   assign ent_age   = now_ff - ent_seen;
   assign ent_valid = slot_valid_ff[chk_idx_ff];
   assign ent_match = ent_valid && (ent_key == key_ff) && (ent_med == med_ff);
   assign ent_stale = ent_valid && !ent_match &&
                      (ent_age > {{TIME_PAD{1'b0}}, lifetime_ff});

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_evicted_count = rsp_count_ff;

   // Configuration writes
   always_comb begin
      window_in   = window_ff;
      lifetime_in = lifetime_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hdf_pkg::CSR_REPEAT_WINDOW:  window_in   = csr_wdata;
            hdf_pkg::CSR_ENTRY_LIFETIME: lifetime_in = csr_wdata;
            default: ;
         endcase
      end
   end

   // Sequencer: scan, update, hand off result
   always_comb begin
      state_in      = state_ff;
      slot_valid_in = slot_valid_ff;
      key_in        = key_ff;
      med_in        = med_ff;
      now_in        = now_ff;
      scan_in       = scan_ff;
      chk_valid_in  = 1'b0;
      chk_idx_in    = scan_ff;
      rep_in        = rep_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      stale_in      = stale_ff;
      cnt_in        = cnt_ff;
      res_status_in = res_status_ff;
      res_count_in  = res_count_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = hit_idx_ff;
      ram_wr_data   = {key_ff, med_ff, now_ff};

      // evaluate one entry per cycle
      if (chk_valid_ff) begin
         if (ent_match) begin
            hit_in     = 1'b1;
            hit_idx_in = chk_idx_ff;
            if (ent_age < {{TIME_PAD{1'b0}}, window_ff}) begin
               rep_in = 1'b1;
            end
         end
         if (ent_stale) begin
            stale_in[chk_idx_ff] = 1'b1;
            if (cnt_ff != hdf_pkg::COUNT_MAX) begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         if (!free_ff && (!ent_valid || ent_stale)) begin
            free_in     = 1'b1;
            free_idx_in = chk_idx_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               key_in   = req_device_key[KEY_BITS-1:0];
               med_in   = req_disc_type;
               now_in   = req_now_ms;
               scan_in  = '0;
               rep_in   = 1'b0;
               hit_in   = 1'b0;
               free_in  = 1'b0;
               stale_in = '0;
               cnt_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            chk_valid_in = 1'b1;
            chk_idx_in   = scan_ff;
            if (scan_ff == LAST_IDX) begin
               state_in = ST_TAIL;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         ST_TAIL: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (rep_ff) begin
               res_status_in = hdf_pkg::STATUS_REPEATED;
               res_count_in  = '0;
            end else begin
               res_count_in  = cnt_ff;
               slot_valid_in = slot_valid_ff & ~stale_ff;
               if (hit_ff) begin
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = hit_idx_ff;
                  res_status_in = hdf_pkg::STATUS_REFRESHED;
               end else if (free_ff) begin
                  ram_wr_en                  = 1'b1;
                  ram_wr_addr                = free_idx_ff;
                  slot_valid_in[free_idx_ff] = 1'b1;
                  res_status_in              = hdf_pkg::STATUS_INSERTED;
               end else begin
                  res_status_in = hdf_pkg::STATUS_FULL;
               end
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_count_in  = res_count_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         window_ff     <= hdf_pkg::REPEAT_WINDOW_RST;
         lifetime_ff   <= hdf_pkg::ENTRY_LIFETIME_RST;
         slot_valid_ff <= '0;
         chk_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         window_ff     <= window_in;
         lifetime_ff   <= lifetime_in;
         slot_valid_ff <= slot_valid_in;
         chk_valid_ff  <= chk_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload and scan bookkeeping registers
   always_ff @(posedge clock) begin
      key_ff        <= key_in;
      med_ff        <= med_in;
      now_ff        <= now_in;
      scan_ff       <= scan_in;
      chk_idx_ff    <= chk_idx_in;
      rep_ff        <= rep_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      free_ff       <= free_in;
      free_idx_ff   <= free_idx_in;
      stale_ff      <= stale_in;
      cnt_ff        <= cnt_in;
      res_status_ff <= res_status_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

endmodule
